// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the filter.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PRF_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prime filter assertion failed");

// Next-cycle implication, disabled during reset
`define PRF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prime filter assertion failed");

`endif

// ===== rtl/prf_pkg.sv =====
// Shared constants and types of the prime removal filter.
// Depends on nothing; used by every module of the block.
package prf_pkg;

   // Width of the tested value and of the divider datapath
   localparam int VALUE_WIDTH = 32;
   // Width of the divider bit counter, able to hold VALUE_WIDTH itself
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   // Sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_START,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Request to the shared divider
   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [VALUE_WIDTH-1:0] divisor;
   } div_req_type;

   // Result of the shared divider
   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
      logic [VALUE_WIDTH-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/prf_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on prf_pkg for the width and the request/result structs.
module prf_divider import prf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   partial;
   logic [VALUE_WIDTH:0]   trial;

   // Shift in the next dividend bit and try to subtract the divisor
   assign partial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign trial   = partial - {1'b0, dsr_ff};

   // Load on start, otherwise step while bits remain
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
         cnt_in = CNT_WIDTH'(VALUE_WIDTH);
      end else if (cnt_ff != '0) begin
         if (trial[VALUE_WIDTH]) begin
            rem_in = partial[VALUE_WIDTH-1:0];
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
         quo_in  = {quo_ff[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
         cnt_in  = cnt_ff - CNT_WIDTH'(1);
         done_in = (cnt_ff == CNT_WIDTH'(1));
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== rtl/prime_removal_filter.sv =====
// Top level of the prime removal filter: sequencer, value register, output register.
// Depends on prf_pkg and prf_divider.

// Each request carries one signed 32-bit value. Prime values are dropped; every
// other value (negative, zero, one, or composite) comes out unchanged on the
// rsp_ channel, in request order. One request is worked on at a time and
// req_ready is low while it is. Negative values, values below four and even
// values are settled by classification alone, plus any wait for a free output
// register. Odd values of five or more are tested against the odd divisors
// 3, 5, 7, ... while divisor <= value / divisor, and each divisor goes through
// the shared bit-serial divider (a load, the quotient bits one by one, then a
// decision), so an odd prime is dropped once the divisor exceeds the quotient;
// an odd composite stops at its smallest factor and then goes on to emit. A kept
// value waits in the output register, and the next request is taken meanwhile.
module prime_removal_filter import prf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_kept_value
);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   load_rsp;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   prf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequence one request through classification and trial division
   always_comb begin
      state_in         = state_ff;
      value_in         = value_ff;
      divisor_in       = divisor_ff;
      req_ready        = 1'b0;
      load_rsp         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = value_ff;
      div_req.divisor  = divisor_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               value_in = $unsigned(req_value);
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            divisor_in = VALUE_WIDTH'(3);
            if (value_ff[VALUE_WIDTH-1] || (value_ff[VALUE_WIDTH-1:1] == '0)) begin
               // negative, zero or one: never prime
               state_in = ST_EMIT;
            end else if (value_ff[VALUE_WIDTH-1:2] == '0) begin
               // two or three: prime, drop
               state_in = ST_IDLE;
            end else if (!value_ff[0]) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            div_req.start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               if (divisor_ff > div_rsp.quotient) begin
                  // no divisor up to the square root: prime, drop
                  state_in = ST_IDLE;
               end else if (div_rsp.remainder == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  divisor_in = divisor_ff + VALUE_WIDTH'(2);
                  state_in   = ST_START;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the kept value until the consumer takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = value_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      divisor_ff   <= divisor_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept_value = $signed(rsp_value_ff);

endmodule

// ===== rtl/prf_checker.sv =====
// Port-level checker of the prime removal filter, with its bind to the top level.
// Depends on prf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prf_checker import prf_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [VALUE_WIDTH-1:0] req_value,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [VALUE_WIDTH-1:0] rsp_kept_value
);

   logic req_fire;

   assign req_fire = req_valid && req_ready && (req_value == req_value);

   // A stalled result stays offered
   `PRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled result keeps its value
   `PRF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_kept_value))

   // An accepted request keeps the block busy in the following cycle
   `PRF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_ready)

   // A new result is loaded only while a request is being worked on
   `PRF_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind prime_removal_filter prf_checker u_prf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_value      (req_value),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kept_value (rsp_kept_value)
);

// ===== bench/prime_removal_filter_tb.sv =====
// Self-checking testbench for prime_removal_filter: drives signed values, predicts which
// values survive (non-primes), and compares each response in request order.
// Depends on prf_pkg and the prime_removal_filter RTL.
`timescale 1ns / 100ps

module prime_removal_filter_tb import prf_pkg::*; ();

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_kept_value;

   // Values waiting to be offered, and values the filter must still pass on
   logic signed [VALUE_WIDTH-1:0] values_to_send [$];
   logic signed [VALUE_WIDTH-1:0] kept_values_due [$];

   int  mismatch_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  req_accepted = 1'b0;
   // Long receiver hold-off, armed by the stimulus and counted by the receiver
   bit  hold_armed = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   prime_removal_filter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kept_value(rsp_kept_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // True when the value is not prime and so must come out of the filter
   function automatic bit is_kept(input logic signed [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] divisor;
      mag = value;
      if (value < 2)
         return 1'b1;
      if (mag < 4)
         return 1'b0;
      if (mag[0] == 1'b0)
         return 1'b1;
      // Odd divisors only; the bound is written as a quotient so it cannot overflow
      for (divisor = 3; divisor <= mag / divisor; divisor += 2) begin
         if (mag % divisor == 0)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // Offer the next value once the previous request has gone through
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (values_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_value <= values_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver readiness: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left = 3000;
         hold_done = 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check responses against the oldest due value, then record new requests
   always @(posedge clock) begin : check_results
      logic signed [VALUE_WIDTH-1:0] expected_value;
      req_accepted = !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (kept_values_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: kept_value expected none, actual %0d", $time, rsp_kept_value);
         end else begin
            expected_value = kept_values_due.pop_front();
            if (rsp_kept_value !== expected_value) begin
               mismatch_count++;
               $display("%0t: kept_value expected %0d, actual %0d",
                        $time, expected_value, rsp_kept_value);
            end
         end
      end
      if (req_accepted && is_kept(req_value))
         kept_values_due.push_back(req_value);
   end

   // Stimulus: directed corner values, then three random phases
   initial begin : stimulus
      logic signed [VALUE_WIDTH-1:0] corner_values [$];
      logic signed [VALUE_WIDTH-1:0] value;
      int                            pick;
      corner_values = '{
         32'sd0, 32'sd1, -32'sd1, -32'sd2, 32'sh8000_0000, 32'sd2, 32'sd3, 32'sd4,
         32'sd5, 32'sd9, 32'sd15, 32'sd17, 32'sd25, 32'sd49, 32'sd97, 32'sd100,
         32'sd121, 32'sd65536, 32'sd65537, 32'sh7FFF_FFFD, 32'sh7FFF_FFFE,
         32'sh7FFF_FFFF, 32'sh5555_5554, 32'sh2AAA_AAAA
      };
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 63;
      foreach (corner_values[i])
         values_to_send.push_back(corner_values[i]);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_armed = 1'b1;
            end
         endcase
         for (int i = 0; i < 25; i++) begin
            pick = $urandom_range(99);
            // Keep large odd values to ones with a small factor so the run stays short
            if (pick < 20)
               value = {1'b1, 31'($urandom)};
            else if (pick < 35)
               value = {1'b0, 30'($urandom), 1'b0};
            else if (pick < 50)
               value = 3 * $urandom_range(1, 715827882);
            else if (pick < 55)
               value = $urandom_range(0, 1 << 20);
            else
               value = $urandom_range(0, 5000);
            values_to_send.push_back(value);
         end
         while (values_to_send.size() != 0 || req_valid)
            @(posedge clock);
      end

      // Drain and give a late stray response time to show up
      while (kept_values_due.size() != 0)
         @(posedge clock);
      repeat (4000) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Hard stop in case the filter hangs
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/prf_pkg.sv
rtl/prf_divider.sv
rtl/prime_removal_filter.sv
rtl/prf_checker.sv
bench/prime_removal_filter_tb.sv
